// ===== sv/prpe_pkg.sv =====
// shared types, widths and arithmetic helpers for the pairwise relative pose encoder
// no dependencies; the cells and the top level refer to this package by scoped names
package prpe_pkg;

   localparam int SQ_W = 49;
   localparam int RAD_W = 2 * SQ_W;
   localparam int DIV_Q = 35;
   localparam int DST_V = 10;
   localparam int LANES_SQ = 3;
   localparam int LANES_ANG = 4;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIUS_ADDR = 3'd0;
   localparam logic [DST_V-1:0] RADIUS_RESET = 10'd100;

   typedef struct packed {
      logic signed [31:0] first_center_x;
      logic signed [31:0] first_center_y;
      logic signed [15:0] first_dir_x;
      logic signed [15:0] first_dir_y;
      logic signed [31:0] second_center_x;
      logic signed [31:0] second_center_y;
      logic signed [15:0] second_dir_x;
      logic signed [15:0] second_dir_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] heading_cos;
      logic signed [15:0] heading_sin;
      logic signed [15:0] bearing_cos;
      logic signed [15:0] bearing_sin;
      logic [31:0] scaled_distance;
   } rsp_type;

   typedef struct packed {
      logic signed [32:0] hd;
      logic signed [32:0] hc;
      logic signed [49:0] bd;
      logic signed [49:0] bc;
   } num_type;

   function automatic logic [SQ_W-1:0] clamp_den(input logic [SQ_W-1:0] r);
      return (r == '0) ? SQ_W'(1) : r;
   endfunction

   function automatic logic [63:0] ang_dividend(input logic signed [49:0] num,
                                                input logic [SQ_W-1:0] den);
      logic [49:0] m;
      m = num[49] ? 50'(-num) : 50'(num);
      return (64'(m) << 14) + 64'(den >> 1);
   endfunction

   function automatic logic [15:0] sat_angle(input logic neg, input logic [DIV_Q-1:0] q);
      logic [15:0] r;
      if (neg) begin
         if (q > DIV_Q'(32768)) r = 16'h8000;
         else r = 16'(~q[15:0] + 16'd1);
      end else begin
         if (q > DIV_Q'(32767)) r = 16'h7fff;
         else r = q[15:0];
      end
      return r;
   endfunction

endpackage

// ===== sv/prpe_chan_if.sv =====
// valid/ready channel carrying one payload item per transfer
// payload type is set at instantiation, normally a struct from prpe_pkg
interface prpe_chan_if #(parameter type payload_type = logic) ();
   logic valid;
   logic ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== sv/prpe_sqrt_cell.sv =====
// one digit step of the integer square root chain: two radicand bits in, one root bit out
// depends on prpe_pkg for the default width
module prpe_sqrt_cell #(
   parameter int W = prpe_pkg::SQ_W
) (
   input  logic           clock,
   input  logic           en,
   input  logic [2*W-1:0] rad_i,
   input  logic [W:0]     rem_i,
   input  logic [W-1:0]   root_i,
   output logic [2*W-1:0] rad_o,
   output logic [W:0]     rem_o,
   output logic [W-1:0]   root_o
);
   logic [2*W-1:0] rad_ff, rad_in;
   logic [W:0]     rem_ff, rem_in;
   logic [W-1:0]   root_ff, root_in;
   logic [W+1:0]   cur, trial, diff;
   logic           ge;

   always_comb begin
      cur = {rem_i[W-1:0], rad_i[2*W-1 -: 2]};
      trial = {root_i, 2'b01};
      diff = cur - trial;
      ge = (cur >= trial);
      rem_in = ge ? diff[W:0] : cur[W:0];
      root_in = {root_i[W-2:0], ge};
      rad_in = {rad_i[2*W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff <= rad_in;
         rem_ff <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rad_o = rad_ff;
   assign rem_o = rem_ff;
   assign root_o = root_ff;
endmodule

// ===== sv/prpe_div_cell.sv =====
// one restoring division step: shifts in one dividend bit, yields one quotient bit
// depends on prpe_pkg for default widths
module prpe_div_cell #(
   parameter int V = prpe_pkg::SQ_W,
   parameter int Q = prpe_pkg::DIV_Q
) (
   input  logic         clock,
   input  logic         en,
   input  logic [Q-1:0] n_i,
   input  logic [V-1:0] rem_i,
   input  logic [Q-1:0] q_i,
   input  logic [V-1:0] dv_i,
   output logic [Q-1:0] n_o,
   output logic [V-1:0] rem_o,
   output logic [Q-1:0] q_o,
   output logic [V-1:0] dv_o
);
   logic [Q-1:0] n_ff, n_in, q_ff, q_in;
   logic [V-1:0] rem_ff, rem_in, dv_ff;
   logic [V:0]   cur, diff;
   logic         ge;

   always_comb begin
      cur = {rem_i, n_i[Q-1]};
      diff = cur - {1'b0, dv_i};
      ge = (cur >= {1'b0, dv_i});
      rem_in = ge ? diff[V-1:0] : cur[V-1:0];
      n_in = {n_i[Q-2:0], 1'b0};
      q_in = {q_i[Q-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff <= n_in;
         rem_ff <= rem_in;
         q_ff <= q_in;
         dv_ff <= dv_i;
      end
   end

   assign n_o = n_ff;
   assign rem_o = rem_ff;
   assign q_o = q_ff;
   assign dv_o = dv_ff;
endmodule

// ===== sv/pairwise_relative_pose_encoder.sv =====
// top level of the pairwise relative pose encoder: product stages, root and divider cell chains
// depends on prpe_pkg, prpe_chan_if, prpe_sqrt_cell and prpe_div_cell
//
// Use: each transfer on req_chan carries one ordered node pair (Q16.16 centers,
// Q2.14 directions); each pair gives exactly one transfer on rsp_chan with the
// heading cos/sin, bearing cos/sin and the scaled distance, in input order.
// The radius register sits at APB address 0; write it only while the block is idle.
// From request transfer to response valid a pair passes five product
// and sum stages, a 49-cell square root chain (one root bit per cell), one
// dividend setup stage, a 35-cell restoring divider chain (one quotient bit per
// cell) and the output buffer. Throughput is one pair per cycle while the
// output buffer has room, the cell chains advancing one step per cycle.
// The output buffer holds two results; the pipeline keeps taking requests while
// a result waits and halts only when both entries are full and unread.
// Reset clears all valid bits and the buffer and sets radius to 100; data in
// flight is dropped.
module pairwise_relative_pose_encoder (
   input  logic clock,
   input  logic reset,
   prpe_chan_if.sink   req_chan,
   prpe_chan_if.source rsp_chan,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [prpe_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   localparam int SQ_W = prpe_pkg::SQ_W;
   localparam int RAD_W = prpe_pkg::RAD_W;
   localparam int DIV_Q = prpe_pkg::DIV_Q;
   localparam int DST_V = prpe_pkg::DST_V;

   logic en;
   logic [DST_V-1:0] radius_ff;

   // register port
   assign pready = 1'b1;
   assign prdata = (paddr == prpe_pkg::CSR_RADIUS_ADDR) ? 32'(radius_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= prpe_pkg::RADIUS_RESET;
      end else if (psel && penable && pwrite && paddr == prpe_pkg::CSR_RADIUS_ADDR) begin
         radius_ff <= pwdata[DST_V-1:0];
      end
   end

   // stage a: capture and displacement
   logic a_v_ff, b_v_ff, c_v_ff, d_v_ff, e_v_ff, f_v_ff;
   logic signed [15:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [32:0] dx_ff, dy_ff;

   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= req_chan.data.first_dir_x;
         ay_ff <= req_chan.data.first_dir_y;
         bx_ff <= req_chan.data.second_dir_x;
         by_ff <= req_chan.data.second_dir_y;
         dx_ff <= 33'(req_chan.data.second_center_x) - 33'(req_chan.data.first_center_x);
         dy_ff <= 33'(req_chan.data.second_center_y) - 33'(req_chan.data.first_center_y);
      end
   end

   // stage b: products
   logic signed [31:0] axbx_ff, ayby_ff, axby_ff, aybx_ff;
   logic signed [48:0] axdx_ff, aydy_ff, axdy_ff, aydx_ff;
   logic [30:0] ax2_ff, ay2_ff, bx2_ff, by2_ff;
   logic [65:0] dx2_ff, dy2_ff;
   logic signed [31:0] ax_sq, ay_sq, bx_sq, by_sq;
   logic [32:0] dx_mag, dy_mag;

   always_comb begin
      ax_sq = ax_ff * ax_ff;
      ay_sq = ay_ff * ay_ff;
      bx_sq = bx_ff * bx_ff;
      by_sq = by_ff * by_ff;
      dx_mag = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
      dy_mag = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         axbx_ff <= ax_ff * bx_ff;
         ayby_ff <= ay_ff * by_ff;
         axby_ff <= ax_ff * by_ff;
         aybx_ff <= ay_ff * bx_ff;
         axdx_ff <= 49'(ax_ff) * 49'(dx_ff);
         aydy_ff <= 49'(ay_ff) * 49'(dy_ff);
         axdy_ff <= 49'(ax_ff) * 49'(dy_ff);
         aydx_ff <= 49'(ay_ff) * 49'(dx_ff);
         ax2_ff <= ax_sq[30:0];
         ay2_ff <= ay_sq[30:0];
         bx2_ff <= bx_sq[30:0];
         by2_ff <= by_sq[30:0];
         dx2_ff <= 66'(dx_mag) * 66'(dx_mag);
         dy2_ff <= 66'(dy_mag) * 66'(dy_mag);
      end
   end

   // stage c: sums
   prpe_pkg::num_type num_c_ff, num_d_ff, num_e_ff;
   logic [31:0] sa_ff, sb_ff;
   logic [65:0] sd_c_ff, sd_d_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         num_c_ff.hd <= 33'(axbx_ff) + 33'(ayby_ff);
         num_c_ff.hc <= 33'(axby_ff) - 33'(aybx_ff);
         num_c_ff.bd <= 50'(axdx_ff) + 50'(aydy_ff);
         num_c_ff.bc <= 50'(axdy_ff) - 50'(aydx_ff);
         sa_ff <= 32'(ax2_ff) + 32'(ay2_ff);
         sb_ff <= 32'(bx2_ff) + 32'(by2_ff);
         sd_c_ff <= dx2_ff + dy2_ff;
      end
   end

   // stage d: norm products, long operand in two halves
   logic [63:0] prod_hb_ff;
   logic [64:0] prod_lo_ff, prod_hi_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_hb_ff <= 64'(sa_ff) * 64'(sb_ff);
         prod_lo_ff <= 65'(sa_ff) * 65'(sd_c_ff[32:0]);
         prod_hi_ff <= 65'(sa_ff) * 65'(sd_c_ff[65:33]);
         sd_d_ff <= sd_c_ff;
         num_d_ff <= num_c_ff;
      end
   end

   // stage e: radicands
   logic [RAD_W-1:0] rad_e_ff [0:2];

   always_ff @(posedge clock) begin
      if (en) begin
         rad_e_ff[0] <= RAD_W'(prod_hb_ff);
         rad_e_ff[1] <= RAD_W'(prod_lo_ff) + (RAD_W'(prod_hi_ff) << 33);
         rad_e_ff[2] <= RAD_W'(sd_d_ff) << 2;
         num_e_ff <= num_d_ff;
      end
   end

   // square root chains: heading norm, bearing norm, twice displacement length
   logic [RAD_W-1:0] sq_rad  [0:2][0:SQ_W];
   logic [SQ_W:0]    sq_rem  [0:2][0:SQ_W];
   logic [SQ_W-1:0]  sq_root [0:2][0:SQ_W];

   for (genvar l = 0; l < 3; l++) begin : g_sq_lane
      assign sq_rad[l][0] = rad_e_ff[l];
      assign sq_rem[l][0] = '0;
      assign sq_root[l][0] = '0;
      for (genvar k = 0; k < SQ_W; k++) begin : g_cell
         prpe_sqrt_cell #(.W(SQ_W)) u_cell (
            .clock  (clock),
            .en     (en),
            .rad_i  (sq_rad[l][k]),
            .rem_i  (sq_rem[l][k]),
            .root_i (sq_root[l][k]),
            .rad_o  (sq_rad[l][k+1]),
            .rem_o  (sq_rem[l][k+1]),
            .root_o (sq_root[l][k+1])
         );
      end
   end

   logic [SQ_W-1:0] sq_v_ff;
   prpe_pkg::num_type num_side_ff [0:SQ_W-1];

   always_ff @(posedge clock) begin
      if (en) begin
         num_side_ff[0] <= num_e_ff;
         for (int i = 1; i < SQ_W; i++) begin
            num_side_ff[i] <= num_side_ff[i-1];
         end
      end
   end

   // stage f: dividends and divisors
   logic [SQ_W-1:0] den_h, den_b;
   logic [63:0] nd [0:3];
   logic [DST_V-1:0] r_eff;
   logic [DIV_Q-1:0] dst_n_f_in;
   prpe_pkg::num_type num_f;

   always_comb begin
      num_f = num_side_ff[SQ_W-1];
      den_h = prpe_pkg::clamp_den(sq_root[0][SQ_W]);
      den_b = prpe_pkg::clamp_den(sq_root[1][SQ_W]);
      nd[0] = prpe_pkg::ang_dividend(50'(num_f.hd), den_h);
      nd[1] = prpe_pkg::ang_dividend(50'(num_f.hc), den_h);
      nd[2] = prpe_pkg::ang_dividend(num_f.bd, den_b);
      nd[3] = prpe_pkg::ang_dividend(num_f.bc, den_b);
      r_eff = (radius_ff == '0) ? DST_V'(1) : radius_ff;
      dst_n_f_in = DIV_Q'(sq_root[2][SQ_W]) + DIV_Q'(r_eff >> 1);
   end

   logic [DIV_Q-1:0] ang_n_f_ff [0:3];
   logic [SQ_W-1:0]  ang_rem_f_ff [0:3];
   logic [SQ_W-1:0]  ang_dv_f_ff [0:3];
   logic [3:0]       neg_f_ff;
   logic [DIV_Q-1:0] dst_n_f_ff;
   logic [DST_V-1:0] dst_dv_f_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            ang_n_f_ff[i] <= nd[i][DIV_Q-1:0];
            ang_rem_f_ff[i] <= SQ_W'(nd[i][63:DIV_Q]);
         end
         ang_dv_f_ff[0] <= den_h;
         ang_dv_f_ff[1] <= den_h;
         ang_dv_f_ff[2] <= den_b;
         ang_dv_f_ff[3] <= den_b;
         neg_f_ff <= {num_f.bc[49], num_f.bd[49], num_f.hc[32], num_f.hd[32]};
         dst_n_f_ff <= dst_n_f_in;
         dst_dv_f_ff <= r_eff;
      end
   end

   // divider chains: four angle lanes and one distance lane
   logic [DIV_Q-1:0] ang_n   [0:3][0:DIV_Q];
   logic [SQ_W-1:0]  ang_rem [0:3][0:DIV_Q];
   logic [DIV_Q-1:0] ang_q   [0:3][0:DIV_Q];
   logic [SQ_W-1:0]  ang_dv  [0:3][0:DIV_Q];
   logic [DIV_Q-1:0] dst_n   [0:DIV_Q];
   logic [DST_V-1:0] dst_rem [0:DIV_Q];
   logic [DIV_Q-1:0] dst_q   [0:DIV_Q];
   logic [DST_V-1:0] dst_dv  [0:DIV_Q];

   for (genvar l = 0; l < 4; l++) begin : g_ang_lane
      assign ang_n[l][0] = ang_n_f_ff[l];
      assign ang_rem[l][0] = ang_rem_f_ff[l];
      assign ang_q[l][0] = '0;
      assign ang_dv[l][0] = ang_dv_f_ff[l];
      for (genvar k = 0; k < DIV_Q; k++) begin : g_cell
         prpe_div_cell #(.V(SQ_W), .Q(DIV_Q)) u_cell (
            .clock (clock),
            .en    (en),
            .n_i   (ang_n[l][k]),
            .rem_i (ang_rem[l][k]),
            .q_i   (ang_q[l][k]),
            .dv_i  (ang_dv[l][k]),
            .n_o   (ang_n[l][k+1]),
            .rem_o (ang_rem[l][k+1]),
            .q_o   (ang_q[l][k+1]),
            .dv_o  (ang_dv[l][k+1])
         );
      end
   end

   assign dst_n[0] = dst_n_f_ff;
   assign dst_rem[0] = '0;
   assign dst_q[0] = '0;
   assign dst_dv[0] = dst_dv_f_ff;

   for (genvar k = 0; k < DIV_Q; k++) begin : g_dst_cell
      prpe_div_cell #(.V(DST_V), .Q(DIV_Q)) u_cell (
         .clock (clock),
         .en    (en),
         .n_i   (dst_n[k]),
         .rem_i (dst_rem[k]),
         .q_i   (dst_q[k]),
         .dv_i  (dst_dv[k]),
         .n_o   (dst_n[k+1]),
         .rem_o (dst_rem[k+1]),
         .q_o   (dst_q[k+1]),
         .dv_o  (dst_dv[k+1])
      );
   end

   logic [DIV_Q-1:0] div_v_ff;
   logic [3:0] neg_side_ff [0:DIV_Q-1];

   always_ff @(posedge clock) begin
      if (en) begin
         neg_side_ff[0] <= neg_f_ff;
         for (int i = 1; i < DIV_Q; i++) begin
            neg_side_ff[i] <= neg_side_ff[i-1];
         end
      end
   end

   // valid bits through the whole pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         sq_v_ff <= '0;
         f_v_ff <= 1'b0;
         div_v_ff <= '0;
      end else if (en) begin
         a_v_ff <= req_chan.valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
         d_v_ff <= c_v_ff;
         e_v_ff <= d_v_ff;
         sq_v_ff <= {sq_v_ff[SQ_W-2:0], e_v_ff};
         f_v_ff <= sq_v_ff[SQ_W-1];
         div_v_ff <= {div_v_ff[DIV_Q-2:0], f_v_ff};
      end
   end

   // result formatting
   prpe_pkg::rsp_type res;
   logic [3:0] neg_out;
   logic [DIV_Q-1:0] dist_q;

   always_comb begin
      neg_out = neg_side_ff[DIV_Q-1];
      dist_q = dst_q[DIV_Q];
      res.heading_cos = prpe_pkg::sat_angle(neg_out[0], ang_q[0][DIV_Q]);
      res.heading_sin = prpe_pkg::sat_angle(neg_out[1], ang_q[1][DIV_Q]);
      res.bearing_cos = prpe_pkg::sat_angle(neg_out[2], ang_q[2][DIV_Q]);
      res.bearing_sin = prpe_pkg::sat_angle(neg_out[3], ang_q[3][DIV_Q]);
      res.scaled_distance = (dist_q[DIV_Q-1:32] != '0) ? 32'hffff_ffff : dist_q[31:0];
   end

   // two-entry output buffer
   prpe_pkg::rsp_type buf_ff [0:1];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign en = (cnt_ff != 2'd2);
   assign push = en && div_v_ff[DIV_Q-1];
   assign pop = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.valid = (cnt_ff != 2'd0);
   assign rsp_chan.data = buf_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop) cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !push) cnt_ff <= cnt_ff - 2'd1;
      end
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("output buffer count out of range");
   a_reset_empty: assert property (@(posedge clock) reset |=> cnt_ff == 2'd0)
      else $error("output buffer not empty after reset");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(div_v_ff) && $stable(sq_v_ff))
      else $error("pipeline moved during stall");
   a_heading_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.data.heading_cos <= 16'sd16385) &&
                         (rsp_chan.data.heading_cos >= -16'sd16385))
      else $error("heading cosine beyond unit magnitude");
`endif
endmodule
